FILE: rtl/two_landmark_position_fix_top_macros.svh
// Assertion macros for the two-landmark position fix.
// Used by the top level; relies on clk and rst_n in the including scope.
`ifndef TWO_LANDMARK_POSITION_FIX_TOP_MACROS_SVH
`define TWO_LANDMARK_POSITION_FIX_TOP_MACROS_SVH

// same-cycle implication
`define TLPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// implication after a fixed number of cycles
`define TLPF_ASSERT_DLY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

FILE: rtl/tlpf_pkg.sv
// Shared constants, types and landmark table for the two-landmark position fix.
// No dependencies.
package tlpf_pkg;

  localparam int NUM_LANDMARKS_DEF = 13;
  localparam int MARK_W  = 4;
  localparam int DIST_W  = 15;
  localparam int BEAR_W  = 12;
  localparam int POS_W   = 16;
  localparam int STAT_W  = 2;
  localparam int COORD_W = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int A_W     = 31;   // dx^2+dy^2 of the field table stays below 2^30
  localparam int PROD_W  = 49;
  localparam int NUM_W   = 52;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;
  localparam int SQ_STEPS = 32;
  localparam int QUO_W   = 17;
  localparam int FRONT_LAT = 5;
  localparam int DIV_LAT = QUO_W + 2;

  localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_MARK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_COINCIDENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_NO_MEET    = 2'd3;

  typedef struct packed {
    logic signed [NUM_W-1:0]  b;
    logic signed [NUM_W-1:0]  c;
    logic signed [DIFF_W-1:0] dx;
    logic signed [DIFF_W-1:0] dy;
    logic [A_W-1:0]           a;
    logic                     neg;
    logic [STAT_W-1:0]        status;
  } side_t;

  // field points {x, y}, 1/256 m
  function automatic logic [2*COORD_W-1:0] mark_point(input logic [MARK_W-1:0] idx);
    logic [2*COORD_W-1:0] p;
    unique case (idx)
      4'd1:    p = {16'hCB80, 16'hE000};
      4'd2:    p = {16'hCB80, 16'h2000};
      4'd3:    p = {16'h3480, 16'h2000};
      4'd4:    p = {16'h3480, 16'hE000};
      4'd5:    p = {16'h0000, 16'hE000};
      4'd6:    p = {16'h0000, 16'h2000};
      4'd7:    p = {16'hE200, 16'hF900};
      4'd8:    p = {16'hE200, 16'h0700};
      4'd9:    p = {16'h1E00, 16'h0700};
      4'd10:   p = {16'h1E00, 16'hF900};
      4'd11:   p = {16'hCB80, 16'h0000};
      4'd12:   p = {16'h3480, 16'h0000};
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

FILE: rtl/two_landmark_position_fix_top.sv
// Two-landmark position fix: circle-circle intersection of two range sightings.
// Depends on tlpf_pkg, tlpf_front, tlpf_sqrt, tlpf_div and the assertion macro header.
//
// Usage:
//  - A request is taken at a rising edge with start high and busy low. busy is
//    high only while rst_n is low, so one request can be issued every cycle.
//  - Each request carries two sightings (landmark index, range in 1/256 m,
//    bearing). Landmarks come from a fixed table of 13 field points.
//  - Exactly one result per request: out_valid is high for one cycle with
//    out_pos_x / out_pos_y (1/256 m, saturated) and out_status.
//  - Pipeline: 5 front stages (lookup, geometry, squares, factors,
//    radicand), 32 square-root stages (one root bit each), one multiply stage,
//    19 divider stages (prep, 17 quotient bits, saturation). Throughput is one
//    request per cycle; the root and divider are fully pipelined.
//  - Status: 0 ok, 1 unknown landmark, 2 coincident landmarks, 3 circles that
//    do not meet. On any error the position reads 0.
//  - Synchronous reset clears all valid bits; requests in flight are dropped.
//  - Results cannot be held off by the receiver; nothing stalls.
`include "two_landmark_position_fix_top_macros.svh"

module two_landmark_position_fix_top #(
  parameter int NUM_LANDMARKS = tlpf_pkg::NUM_LANDMARKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [tlpf_pkg::MARK_W-1:0]         in_first_mark,
  input  logic [tlpf_pkg::DIST_W-1:0]         in_first_distance,
  input  logic signed [tlpf_pkg::BEAR_W-1:0]  in_first_bearing,
  input  logic [tlpf_pkg::MARK_W-1:0]         in_second_mark,
  input  logic [tlpf_pkg::DIST_W-1:0]         in_second_distance,
  input  logic signed [tlpf_pkg::BEAR_W-1:0]  in_second_bearing,
  output logic                                out_valid,
  output logic signed [tlpf_pkg::POS_W-1:0]   out_pos_x,
  output logic signed [tlpf_pkg::POS_W-1:0]   out_pos_y,
  output logic [tlpf_pkg::STAT_W-1:0]         out_status
);

  localparam int NW  = tlpf_pkg::NUM_W;
  localparam int LAT = tlpf_pkg::FRONT_LAT + tlpf_pkg::SQ_STEPS + 1 + tlpf_pkg::DIV_LAT;

  logic in_req;

  assign busy   = ~rst_n;
  assign in_req = start & ~busy;

  // front: lookup, geometry, radicand
  logic                        fr_valid;
  logic [tlpf_pkg::RAD_W-1:0]  fr_rad;
  tlpf_pkg::side_t             fr_side;

  tlpf_front #(
    .NUM_LANDMARKS(NUM_LANDMARKS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .valid_i         (in_req),
    .first_mark      (in_first_mark),
    .first_distance  (in_first_distance),
    .first_bearing   (in_first_bearing),
    .second_mark     (in_second_mark),
    .second_distance (in_second_distance),
    .second_bearing  (in_second_bearing),
    .valid_o         (fr_valid),
    .rad_o           (fr_rad),
    .side_o          (fr_side)
  );

  // root of the product of the two factors
  logic                        sq_valid;
  logic [tlpf_pkg::ROOT_W-1:0] sq_root;
  tlpf_pkg::side_t             sq_side;

  tlpf_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (fr_valid),
    .rad_i   (fr_rad),
    .side_i  (fr_side),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // D*dy and D*dx, then pick the side of the baseline from the sign of the bearing difference
  logic                         m_valid_r;
  logic signed [NW-1:0]         nx_r, ny_r, nx_nxt, ny_nxt;
  logic [tlpf_pkg::A_W-1:0]     ma_r;
  logic [tlpf_pkg::STAT_W-1:0]  mst_r;
  logic signed [tlpf_pkg::ROOT_W:0] d_s;
  logic signed [NW-1:0]         ddx, ddy;

  assign d_s = signed'({1'b0, sq_root});
  assign ddx = NW'(d_s * sq_side.dx);
  assign ddy = NW'(d_s * sq_side.dy);

  always_comb begin
    if (sq_side.neg) begin
      nx_nxt = sq_side.b - ddy;
      ny_nxt = sq_side.c + ddx;
    end else begin
      nx_nxt = sq_side.b + ddy;
      ny_nxt = sq_side.c - ddx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else begin
      m_valid_r <= sq_valid;
    end
    nx_r  <= nx_nxt;
    ny_r  <= ny_nxt;
    ma_r  <= sq_side.a;
    mst_r <= sq_side.status;
  end

  // rounding dividers, x and y in lockstep
  logic dvx_valid, dvy_valid;
  logic signed [tlpf_pkg::POS_W-1:0] qx, qy;

  tlpf_div u_div_x (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (m_valid_r),
    .num_i   (nx_r),
    .a_i     (ma_r),
    .valid_o (dvx_valid),
    .q_o     (qx)
  );

  tlpf_div u_div_y (
    .clk     (clk),
    .rst_n   (rst_n),
    .valid_i (m_valid_r),
    .num_i   (ny_r),
    .a_i     (ma_r),
    .valid_o (dvy_valid),
    .q_o     (qy)
  );

  // status rides alongside the divider
  logic [tlpf_pkg::STAT_W-1:0] st_r [0:tlpf_pkg::DIV_LAT-1];

  always_ff @(posedge clk) begin
    st_r[0] <= mst_r;
  end

  for (genvar i = 1; i < tlpf_pkg::DIV_LAT; i++) begin : g_st
    always_ff @(posedge clk) begin
      st_r[i] <= st_r[i-1];
    end
  end

  logic st_ok;
  assign st_ok      = (st_r[tlpf_pkg::DIV_LAT-1] == tlpf_pkg::ST_OK);
  assign out_valid  = dvx_valid;
  assign out_status = st_r[tlpf_pkg::DIV_LAT-1];
  assign out_pos_x  = st_ok ? qx : '0;
  assign out_pos_y  = st_ok ? qy : '0;

  // checks
  `TLPF_ASSERT_NOW(a_div_lockstep, 1'b1, dvx_valid == dvy_valid, "x/y dividers out of step")
  `TLPF_ASSERT_DLY(a_req_to_result, in_req, LAT, out_valid, "request produced no result")
  `TLPF_ASSERT_NOW(a_result_has_req, out_valid, $past(in_req, LAT), "result without request")

endmodule

FILE: rtl/tlpf_front.sv
// Front pipeline: landmark lookup, circle geometry, radicand and numerators.
// Depends on tlpf_pkg.
module tlpf_front #(
  parameter int NUM_LANDMARKS = tlpf_pkg::NUM_LANDMARKS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  input  logic [tlpf_pkg::MARK_W-1:0]         first_mark,
  input  logic [tlpf_pkg::DIST_W-1:0]         first_distance,
  input  logic signed [tlpf_pkg::BEAR_W-1:0]  first_bearing,
  input  logic [tlpf_pkg::MARK_W-1:0]         second_mark,
  input  logic [tlpf_pkg::DIST_W-1:0]         second_distance,
  input  logic signed [tlpf_pkg::BEAR_W-1:0]  second_bearing,
  output logic                                valid_o,
  output logic [tlpf_pkg::RAD_W-1:0]          rad_o,
  output tlpf_pkg::side_t                     side_o
);

  localparam int CW = tlpf_pkg::COORD_W;
  localparam int DW = tlpf_pkg::DIFF_W;
  localparam int RW = tlpf_pkg::DIST_W;
  localparam int AW = tlpf_pkg::A_W;
  localparam int PW = tlpf_pkg::PROD_W;
  localparam int NW = tlpf_pkg::NUM_W;

  // stage 1: lookup
  logic v1_r, v1_nxt;
  logic signed [CW-1:0] x1_r, y1_r, x2_r, y2_r;
  logic [RW-1:0] r1_1_r, r2_1_r;
  logic neg1_r, bad1_r;
  logic [2*CW-1:0] p1, p2;
  logic signed [tlpf_pkg::BEAR_W:0] bdiff;

  assign p1    = tlpf_pkg::mark_point(first_mark);
  assign p2    = tlpf_pkg::mark_point(second_mark);
  assign bdiff = (tlpf_pkg::BEAR_W+1)'(second_bearing) - (tlpf_pkg::BEAR_W+1)'(first_bearing);
  assign v1_nxt = valid_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
    end
    x1_r   <= p1[2*CW-1:CW];
    y1_r   <= p1[CW-1:0];
    x2_r   <= p2[2*CW-1:CW];
    y2_r   <= p2[CW-1:0];
    r1_1_r <= first_distance;
    r2_1_r <= second_distance;
    neg1_r <= bdiff < 0;
    bad1_r <= ({1'b0, first_mark} >= 5'(NUM_LANDMARKS)) ||
              ({1'b0, second_mark} >= 5'(NUM_LANDMARKS));
  end

  // stage 2: differences and sums
  logic v2_r;
  logic signed [DW-1:0] dx2_r, dy2_r, sx2_r, sy2_r;
  logic [RW:0] rsum2_r;
  logic signed [RW:0] rdiff2_r;
  logic neg2_r, bad2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    dx2_r    <= DW'(x1_r) - DW'(x2_r);
    dy2_r    <= DW'(y1_r) - DW'(y2_r);
    sx2_r    <= DW'(x1_r) + DW'(x2_r);
    sy2_r    <= DW'(y1_r) + DW'(y2_r);
    rsum2_r  <= (RW+1)'(r1_1_r) + (RW+1)'(r2_1_r);
    rdiff2_r <= signed'({1'b0, r1_1_r}) - signed'({1'b0, r2_1_r});
    neg2_r   <= neg1_r;
    bad2_r   <= bad1_r;
  end

  // stage 3: squares
  logic v3_r;
  logic [AW-1:0] a3_r;
  logic [2*RW+1:0] rs2_3_r;
  logic [2*RW+1:0] rd2_3_r;
  logic signed [2*RW+1:0] k3_r;
  logic signed [DW-1:0] dx3_r, dy3_r, sx3_r, sy3_r;
  logic neg3_r, bad3_r;
  logic signed [2*DW-1:0] dxx, dyy;
  logic signed [2*RW+1:0] rdd;
  logic signed [2*RW+2:0] kp;

  assign dxx = dx2_r * dx2_r;
  assign dyy = dy2_r * dy2_r;
  assign rdd = rdiff2_r * rdiff2_r;
  assign kp  = rdiff2_r * signed'({1'b0, rsum2_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    a3_r    <= dxx[AW-1:0] + dyy[AW-1:0];
    rs2_3_r <= rsum2_r * rsum2_r;
    rd2_3_r <= rdd;
    k3_r    <= (2*RW+2)'(-kp);
    dx3_r   <= dx2_r;
    dy3_r   <= dy2_r;
    sx3_r   <= sx2_r;
    sy3_r   <= sy2_r;
    neg3_r  <= neg2_r;
    bad3_r  <= bad2_r;
  end

  // stage 4: factors, status and partial products
  logic v4_r;
  logic signed [2*RW+3:0] f1_4_r;
  logic signed [2*RW+2:0] f2_4_r;
  logic signed [PW-1:0] kdx_r, kdy_r, sxa_r, sya_r;
  logic [tlpf_pkg::STAT_W-1:0] st4_r, st4_nxt;
  logic signed [DW-1:0] dx4_r, dy4_r;
  logic [AW-1:0] a4_r;
  logic neg4_r;
  logic signed [2*RW+3:0] f1_nxt;
  logic signed [2*RW+2:0] f2_nxt;
  logic signed [AW:0] a_s;

  assign a_s    = signed'({1'b0, a3_r});
  assign f1_nxt = signed'({2'b0, rs2_3_r}) - (2*RW+4)'(a_s);
  assign f2_nxt = (2*RW+3)'(a_s) - signed'({1'b0, rd2_3_r});

  always_comb begin
    priority if (bad3_r) begin
      st4_nxt = tlpf_pkg::ST_BAD_MARK;
    end else if (a3_r == '0) begin
      st4_nxt = tlpf_pkg::ST_COINCIDENT;
    end else if (f1_nxt < 0 || f2_nxt < 0) begin
      st4_nxt = tlpf_pkg::ST_NO_MEET;
    end else begin
      st4_nxt = tlpf_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else begin
      v4_r <= v3_r;
    end
    f1_4_r <= f1_nxt;
    f2_4_r <= f2_nxt;
    kdx_r  <= PW'(k3_r * dx3_r);
    kdy_r  <= PW'(k3_r * dy3_r);
    sxa_r  <= PW'(sx3_r * a_s);
    sya_r  <= PW'(sy3_r * a_s);
    st4_r  <= st4_nxt;
    dx4_r  <= dx3_r;
    dy4_r  <= dy3_r;
    a4_r   <= a3_r;
    neg4_r <= neg3_r;
  end

  // stage 5: radicand and numerator bases
  logic v5_r;
  logic [tlpf_pkg::RAD_W-1:0] rad5_r;
  tlpf_pkg::side_t side5_r, side5_nxt;
  logic ok4;

  assign ok4 = (st4_r == tlpf_pkg::ST_OK);

  always_comb begin
    side5_nxt.b      = NW'(kdx_r) + NW'(sxa_r);
    side5_nxt.c      = NW'(kdy_r) + NW'(sya_r);
    side5_nxt.dx     = dx4_r;
    side5_nxt.dy     = dy4_r;
    side5_nxt.a      = a4_r;
    side5_nxt.neg    = neg4_r;
    side5_nxt.status = st4_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else begin
      v5_r <= v4_r;
    end
    rad5_r  <= ok4 ? tlpf_pkg::RAD_W'(f1_4_r[32:0] * f2_4_r[30:0]) : '0;
    side5_r <= side5_nxt;
  end

  assign valid_o = v5_r;
  assign rad_o   = rad5_r;
  assign side_o  = side5_r;

endmodule

FILE: rtl/tlpf_sqrt.sv
// Pipelined integer square root, one result bit per stage, side data carried along.
// Depends on tlpf_pkg.
module tlpf_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          valid_i,
  input  logic [tlpf_pkg::RAD_W-1:0]    rad_i,
  input  tlpf_pkg::side_t               side_i,
  output logic                          valid_o,
  output logic [tlpf_pkg::ROOT_W-1:0]   root_o,
  output tlpf_pkg::side_t               side_o
);

  localparam int N  = tlpf_pkg::SQ_STEPS;
  localparam int RW = tlpf_pkg::RAD_W;

  logic            v_r    [0:N];
  logic [RW-1:0]   rem_r  [0:N];
  logic [RW-1:0]   root_r [0:N];
  tlpf_pkg::side_t side_r [0:N];

  always_comb begin
    v_r[0]    = valid_i;
    rem_r[0]  = rad_i;
    root_r[0] = '0;
    side_r[0] = side_i;
  end

  for (genvar s = 0; s < N; s++) begin : g_step
    localparam logic [RW-1:0] BIT = RW'(1) << (2*(N-1-s));
    logic [RW-1:0] trial, rem_nxt, root_nxt;

    always_comb begin
      trial = root_r[s] + BIT;
      if (rem_r[s] >= trial) begin
        rem_nxt  = rem_r[s] - trial;
        root_nxt = (root_r[s] >> 1) + BIT;
      end else begin
        rem_nxt  = rem_r[s];
        root_nxt = root_r[s] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else begin
        v_r[s+1] <= v_r[s];
      end
      rem_r[s+1]  <= rem_nxt;
      root_r[s+1] <= root_nxt;
      side_r[s+1] <= side_r[s];
    end
  end

  assign valid_o = v_r[N];
  assign root_o  = root_r[N][tlpf_pkg::ROOT_W-1:0];
  assign side_o  = side_r[N];

endmodule

FILE: rtl/tlpf_div.sv
// Pipelined n/(2a) with round-half-away and 16-bit saturation, one quotient bit per stage.
// Depends on tlpf_pkg.
module tlpf_div (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                valid_i,
  input  logic signed [tlpf_pkg::NUM_W-1:0]   num_i,
  input  logic [tlpf_pkg::A_W-1:0]            a_i,
  output logic                                valid_o,
  output logic signed [tlpf_pkg::POS_W-1:0]   q_o
);

  localparam int NW = tlpf_pkg::NUM_W;
  localparam int QW = tlpf_pkg::QUO_W;
  localparam int DW = tlpf_pkg::A_W + 1;

  logic          v_r   [0:QW];
  logic [NW-1:0] rem_r [0:QW];
  logic [DW-1:0] d2_r  [0:QW];
  logic [QW-1:0] q_r   [0:QW];
  logic          neg_r [0:QW];
  logic          ovf_r [0:QW];
  logic [NW-1:0] mag;

  // prep: magnitude plus half divisor
  assign mag = (num_i < 0 ? NW'(-num_i) : NW'(num_i)) + NW'(a_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= valid_i;
    end
    rem_r[0] <= mag;
    d2_r[0]  <= {a_i, 1'b0};
    q_r[0]   <= '0;
    neg_r[0] <= num_i < 0;
    ovf_r[0] <= 1'b0;
  end

  for (genvar j = 0; j < QW; j++) begin : g_bit
    logic [NW-1:0] sub;
    logic          ovf_nxt;

    assign sub = NW'(d2_r[j]) << (QW-1-j);
    if (j == 0) begin : g_ovf
      assign ovf_nxt = rem_r[j] >= (NW'(d2_r[j]) << QW);
    end else begin : g_keep
      assign ovf_nxt = ovf_r[j];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else begin
        v_r[j+1] <= v_r[j];
      end
      if (rem_r[j] >= sub) begin
        rem_r[j+1] <= rem_r[j] - sub;
        q_r[j+1]   <= q_r[j] | (QW'(1) << (QW-1-j));
      end else begin
        rem_r[j+1] <= rem_r[j];
        q_r[j+1]   <= q_r[j];
      end
      d2_r[j+1]  <= d2_r[j];
      neg_r[j+1] <= neg_r[j];
      ovf_r[j+1] <= ovf_nxt;
    end
  end

  // saturate and apply sign
  logic v_out_r;
  logic signed [tlpf_pkg::POS_W-1:0] q_out_r, q_nxt;
  logic [QW-1:0] qf;

  assign qf = q_r[QW];

  always_comb begin
    if (neg_r[QW]) begin
      if (ovf_r[QW] || qf > QW'(32768)) begin
        q_nxt = {1'b1, {(tlpf_pkg::POS_W-1){1'b0}}};
      end else begin
        q_nxt = tlpf_pkg::POS_W'(-signed'({1'b0, qf}));
      end
    end else begin
      if (ovf_r[QW] || qf > QW'(32767)) begin
        q_nxt = {1'b0, {(tlpf_pkg::POS_W-1){1'b1}}};
      end else begin
        q_nxt = signed'(tlpf_pkg::POS_W'(qf));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_out_r <= 1'b0;
    end else begin
      v_out_r <= v_r[QW];
    end
    q_out_r <= q_nxt;
  end

  assign valid_o = v_out_r;
  assign q_o     = q_out_r;

endmodule
